FILE: design/swcm_pkg.sv
package swcm_pkg;

   localparam int MAX_OUT_DEF   = 16;
   localparam int MAX_CHUNK_DEF = 16;
   localparam int ROW_W   = 4;
   localparam int COL_W   = 4;
   localparam int VAL_W   = 16;
   localparam int ACC_W   = 32;
   localparam int IDX_W   = 8;
   localparam int CSR_W   = 5;
   localparam int MODE_W  = 3;
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;

   localparam logic CSR_CHUNK_SIZE = 1'b0;
   localparam logic CSR_OUT_SIZE   = 1'b1;

   typedef enum logic [2:0] {
      MODE_LOAD_W   = 3'd0,
      MODE_FORWARD  = 3'd1,
      MODE_LOAD_ERR = 3'd2,
      MODE_BACKWARD = 3'd3,
      MODE_READ_D   = 3'd4,
      MODE_CLEAR_D  = 3'd5
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FWD_RD,
      ST_FWD_NEXT,
      ST_FWD_MUL,
      ST_FWD_ACC,
      ST_OUT_RD,
      ST_OUT_SEND,
      ST_BWD_RD,
      ST_BWD_MUL,
      ST_BWD_ACC,
      ST_BWD_SEND,
      ST_RDD_RD,
      ST_RDD_SEND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch accepted request
      logic wr_weight;
      logic wr_error;
      logic rd_mem;      // read weight/deriv at row counter
      logic mul;         // register products
      logic fwd_acc;     // add into forward sum of row counter
      logic bwd_acc;     // add into backward acc and deriv store
      logic clr_acc;     // clear backward accumulator
      logic clr_row;     // zero forward sum of row counter, or every sum with out_last
      logic clr_d;       // zero derivative entry at clear counter
      logic load_out;    // present result
      logic out_fwd;     // result comes from forward sums
      logic out_rdd;     // result comes from derivative read
      logic out_last;
   } cmd_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s > 33'sh0_7FFF_FFFF)       sat_add = 32'sh7FFF_FFFF;
      else if (s < -33'sh0_8000_0000) sat_add = 32'sh8000_0000;
      else                            sat_add = s[31:0];
   endfunction

endpackage

FILE: design/swcm_ram.sv
module swcm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: design/swcm_datapath.sv
module swcm_datapath import swcm_pkg::*; #(
   parameter int MAX_OUT   = MAX_OUT_DEF,
   parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [ROW_W-1:0]      row_cnt,
   input  logic [$clog2(MAX_OUT*MAX_CHUNK)-1:0] clr_cnt,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   output logic [2:0]            mode,
   output logic [COL_W-1:0]      column,
   output logic                  last_element,
   output logic [RSP_DATA_W-1:0] out_data,
   output logic                  out_last
);
   localparam int AW  = $clog2(MAX_OUT * MAX_CHUNK);
   localparam int RW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
   localparam int CW  = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;

   logic [2:0]              mode_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [COL_W-1:0]        col_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic                    last_ff;

   logic signed [ACC_W-1:0] fsum_ff [MAX_OUT];
   logic signed [VAL_W-1:0] err_ff  [MAX_OUT];
   logic signed [ACC_W-1:0] bacc_ff;
   logic signed [ACC_W-1:0] prod_a_ff, prod_b_ff;
   logic [AW-1:0]           ent_ff;
   logic [RSP_DATA_W-1:0]   out_ff;
   logic                    out_last_ff;

   logic signed [VAL_W-1:0] w_rd;
   logic signed [ACC_W-1:0] d_rd;
   logic                    d_we;
   logic [AW-1:0]           d_waddr;
   logic signed [ACC_W-1:0] d_wdata;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           req_addr;
   logic                    entry_ok;
   logic [RW-1:0]           rc;
   logic [RW-1:0]           rq;

   assign mode         = mode_ff;
   assign column       = col_ff;
   assign last_element = last_ff;
   assign out_data     = out_ff;
   assign out_last     = out_last_ff;

   assign rc = RW'(row_cnt);
   assign rq = RW'(row_ff);
   assign entry_ok = (32'(row_ff) < MAX_OUT) && (32'(col_ff) < MAX_CHUNK);
   assign req_addr = AW'(32'(row_ff) * MAX_CHUNK + 32'(col_ff));
   assign rd_addr  = (mode_ff == MODE_READ_D) ? req_addr
                     : AW'(32'(row_cnt) * MAX_CHUNK + 32'(col_ff));

   swcm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_OUT * MAX_CHUNK)) u_wram (
      .clock(clock), .we(cmd.wr_weight && entry_ok), .waddr(req_addr),
      .wdata(val_ff), .raddr(rd_addr), .rdata(w_rd));

   always_comb begin
      d_we    = 1'b0;
      d_waddr = ent_ff;
      d_wdata = sat_add(d_rd, prod_b_ff);
      if (cmd.clr_d) begin
         d_we    = 1'b1;
         d_waddr = clr_cnt;
         d_wdata = '0;
      end else if (cmd.bwd_acc) begin
         d_we = 1'b1;
      end
   end

   swcm_ram #(.WIDTH(ACC_W), .DEPTH(MAX_OUT * MAX_CHUNK)) u_dram (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .raddr(rd_addr), .rdata(d_rd));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_tuser;
         row_ff  <= req_tdata[3:0];
         col_ff  <= req_tdata[7:4];
         val_ff  <= req_tdata[23:8];
         last_ff <= req_tlast;
      end
      if (cmd.wr_error && (32'(row_ff) < MAX_OUT)) begin
         err_ff[rq] <= val_ff;
      end
      if (cmd.rd_mem) begin
         ent_ff <= rd_addr;
      end
      if (cmd.mul) begin
         prod_a_ff <= ((mode_ff == MODE_FORWARD) ? w_rd : err_ff[rc]) *
                      ((mode_ff == MODE_FORWARD) ? val_ff : w_rd);
         prod_b_ff <= err_ff[rc] * val_ff;
      end
      if (cmd.clr_acc) begin
         bacc_ff <= '0;
      end else if (cmd.bwd_acc) begin
         bacc_ff <= sat_add(bacc_ff, prod_a_ff);
      end
      // the final sum sent clears every row
      for (int i = 0; i < MAX_OUT; i++) begin
         if (reset) begin
            fsum_ff[i] <= '0;
         end else if (cmd.fwd_acc && RW'(i) == rc) begin
            fsum_ff[i] <= sat_add(fsum_ff[i], prod_a_ff);
         end else if (cmd.clr_row && (RW'(i) == rc || cmd.out_last)) begin
            fsum_ff[i] <= '0;
         end
      end
      if (cmd.load_out) begin
         out_last_ff <= cmd.out_last;
         if (cmd.out_fwd) begin
            out_ff <= {IDX_W'(row_cnt), fsum_ff[rc]};
         end else if (cmd.out_rdd) begin
            out_ff <= {row_ff, col_ff, entry_ok ? d_rd : ACC_W'(0)};
         end else begin
            out_ff <= {4'b0, col_ff, bacc_ff};
         end
      end
   end
endmodule

FILE: design/swcm_ctrl.sv
module swcm_ctrl import swcm_pkg::*; #(
   parameter int MAX_OUT   = MAX_OUT_DEF,
   parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic [2:0]       mode,
   input  logic [COL_W-1:0] column,
   input  logic             last_element,
   output cmd_type          cmd,
   output logic [ROW_W-1:0] row_cnt,
   output logic [$clog2(MAX_OUT*MAX_CHUNK)-1:0] clr_cnt
);
   localparam int AW    = $clog2(MAX_OUT * MAX_CHUNK);
   localparam int OLIM  = (MAX_OUT < 16) ? MAX_OUT : 16;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             vld_ff, vld_in;
   logic [CSR_W-1:0] chunk_ff, out_ff;
   logic [CSR_W-1:0] nc, no;
   logic             col_ok, row_end;

   assign row_cnt    = row_ff;
   assign clr_cnt    = clr_ff;
   assign rsp_tvalid = vld_ff;

   always_comb begin
      nc = chunk_ff;
      if (chunk_ff == '0) nc = CSR_W'(1);
      else if (32'(chunk_ff) > MAX_CHUNK) nc = CSR_W'(MAX_CHUNK);
      no = out_ff;
      if (out_ff == '0) no = CSR_W'(1);
      else if (32'(out_ff) > OLIM) no = CSR_W'(OLIM);
   end
   assign col_ok  = {1'b0, column} < nc;
   assign row_end = (CSR_W'(row_ff) + CSR_W'(1)) == no;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         row_ff   <= '0;
         clr_ff   <= '0;
         vld_ff   <= 1'b0;
         chunk_ff <= CSR_W'(1);
         out_ff   <= CSR_W'(1);
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         clr_ff   <= clr_in;
         vld_ff   <= vld_in;
         if (csr_we && csr_addr == CSR_CHUNK_SIZE) chunk_ff <= csr_wdata;
         if (csr_we && csr_addr == CSR_OUT_SIZE)   out_ff   <= csr_wdata;
      end
   end

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      clr_in     = clr_ff;
      vld_in     = vld_ff && !rsp_tready;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_d = 1'b1;
            clr_in    = clr_ff + AW'(1);
            if (32'(clr_ff) == MAX_OUT * MAX_CHUNK - 1) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready  = !vld_ff || rsp_tready;
            cmd.capture = req_tvalid && req_tready;
            if (cmd.capture) state_in = ST_FWD_RD; // decode next cycle
            row_in = '0;
         end
         ST_FWD_RD: begin
            // decode the held request
            row_in = '0;
            unique case (mode)
               MODE_LOAD_W:   begin cmd.wr_weight = 1'b1; state_in = ST_IDLE; end
               MODE_LOAD_ERR: begin cmd.wr_error = 1'b1; state_in = ST_IDLE; end
               MODE_CLEAR_D:  state_in = ST_CLEAR;
               MODE_FORWARD:  state_in = col_ok ? ST_FWD_MUL : ST_OUT_RD;
               MODE_BACKWARD: begin
                  cmd.clr_acc = 1'b1;
                  state_in = col_ok ? ST_BWD_MUL : ST_BWD_SEND;
               end
               MODE_READ_D:   state_in = ST_RDD_RD;
               default:       state_in = ST_IDLE;
            endcase
            if (mode == MODE_FORWARD || mode == MODE_BACKWARD) cmd.rd_mem = 1'b1;
         end
         ST_FWD_NEXT: begin
            // weight of the new row is addressed now
            state_in = ST_FWD_MUL;
         end
         ST_FWD_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FWD_ACC;
         end
         ST_FWD_ACC: begin
            cmd.fwd_acc = 1'b1;
            if (row_end) begin
               row_in   = '0;
               state_in = ST_OUT_RD;
            end else begin
               row_in   = row_ff + ROW_W'(1);
               state_in = ST_FWD_NEXT;
            end
         end
         ST_OUT_RD: begin
            if (!last_element) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_OUT_SEND;
            end
         end
         ST_OUT_SEND: begin
            if (!vld_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               cmd.out_fwd  = 1'b1;
               cmd.out_last = row_end;
               cmd.clr_row  = 1'b1;
               vld_in       = 1'b1;
               if (row_end) begin
                  row_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
         ST_BWD_RD: begin
            // address weight and derivative of the new row
            cmd.rd_mem = 1'b1;
            state_in   = ST_BWD_MUL;
         end
         ST_BWD_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_BWD_ACC;
         end
         ST_BWD_ACC: begin
            cmd.bwd_acc = 1'b1;
            if (row_end) begin
               state_in = ST_BWD_SEND;
            end else begin
               row_in   = row_ff + ROW_W'(1);
               state_in = ST_BWD_RD;
            end
         end
         ST_BWD_SEND: begin
            if (!vld_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               cmd.out_last = 1'b1;
               vld_in       = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RDD_RD: state_in = ST_RDD_SEND;
         ST_RDD_SEND: begin
            if (!vld_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               cmd.out_rdd  = 1'b1;
               cmd.out_last = 1'b1;
               vld_in       = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

FILE: design/shared_weight_chunk_matvec.sv
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tuser: mode; tdata: row, column, value; tlast: last_element
// rsp      out  rsp_tvalid/rsp_tready  tdata: result_value, result_index; tlast: result_last
// csr      in   csr_we                 csr_addr, csr_wdata
// between accepted words, a load writes its store, a derivative read reads its entry and
// then sends it, and a forward or backward element reads, multiplies and accumulates each
// row in turn on the shared multiply-accumulate datapath with registered-read memories;
// a column past the chunk skips the rows. forward sums are sent one row at a time.
// after reset, and on a clear, the derivative memory is swept over all its entries,
// one entry a cycle, while no word is accepted.
// a stalled result holds in the output register; the block then waits.
module shared_weight_chunk_matvec import swcm_pkg::*; #(
   parameter int MAX_OUT   = MAX_OUT_DEF,
   parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // row, column, value
   input  logic [REQ_USER_W-1:0] req_tuser,  // mode
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // result_value, result_index
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);
   cmd_type          cmd;
   logic [ROW_W-1:0] row_cnt;
   logic [$clog2(MAX_OUT*MAX_CHUNK)-1:0] clr_cnt;
   logic [2:0]       mode;
   logic [COL_W-1:0] column;
   logic             last_element;

   swcm_ctrl #(.MAX_OUT(MAX_OUT), .MAX_CHUNK(MAX_CHUNK)) u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .csr_we, .csr_addr, .csr_wdata, .mode, .column, .last_element,
      .cmd, .row_cnt, .clr_cnt);

   swcm_datapath #(.MAX_OUT(MAX_OUT), .MAX_CHUNK(MAX_CHUNK)) u_dp (
      .clock, .reset, .cmd, .row_cnt, .clr_cnt, .req_tdata, .req_tuser, .req_tlast,
      .mode, .column, .last_element, .out_data(rsp_tdata), .out_last(rsp_tlast));
endmodule

FILE: tb/shared_weight_chunk_matvec_tb.sv
`default_nettype none

module shared_weight_chunk_matvec_tb;
   import swcm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NROWS = MAX_OUT_DEF;
   localparam int NCOLS = MAX_CHUNK_DEF;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic signed [ACC_W-1:0] value;
      logic [IDX_W-1:0]        index;
      logic                    last;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic csr_addr = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // layer state mirrored in the testbench
   logic signed [VAL_W-1:0] weights [NROWS*NCOLS];
   logic signed [ACC_W-1:0] derivs [NROWS*NCOLS];
   logic signed [ACC_W-1:0] row_sums [NROWS];
   logic signed [VAL_W-1:0] errors [NROWS];
   logic [CSR_W-1:0] chunk_reg, out_reg;

   result_type pending_results[$];
   int errors_seen = 0;
   int idle_cycles = 0;

   shared_weight_chunk_matvec uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic signed [ACC_W-1:0] clamp_add(logic signed [ACC_W-1:0] a,
                                                          longint b);
      longint s;
      s = longint'(a) + b;
      if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (s < -64'sd2147483648) return 32'sh8000_0000;
      return s[31:0];
   endfunction

   function automatic int cols_used();
      if (chunk_reg == 0) return 1;
      if (chunk_reg > NCOLS) return NCOLS;
      return int'(chunk_reg);
   endfunction

   function automatic int rows_used();
      if (out_reg == 0) return 1;
      if (out_reg > NROWS) return NROWS;
      return int'(out_reg);
   endfunction

   // updates the mirrored layer and queues the words the block must return
   function automatic void layer_step(logic [2:0] mode, logic [3:0] row, logic [3:0] col,
                                      logic signed [VAL_W-1:0] val, logic last);
      int nc, no;
      int e;
      logic signed [ACC_W-1:0] acc;
      result_type w;
      nc = cols_used();
      no = rows_used();
      case (mode)
         MODE_LOAD_W: weights[row*NCOLS+col] = val;
         MODE_FORWARD: begin
            if (col < nc)
               for (int j = 0; j < no; j++)
                  row_sums[j] = clamp_add(row_sums[j],
                                          longint'(weights[j*NCOLS+col]) * longint'(val));
            if (last) begin
               for (int j = 0; j < no; j++) begin
                  w.value = row_sums[j];
                  w.index = IDX_W'(j);
                  w.last  = (j == no-1);
                  pending_results.push_back(w);
               end
               foreach (row_sums[j]) row_sums[j] = '0;
            end
         end
         MODE_LOAD_ERR: errors[row] = val;
         MODE_BACKWARD: begin
            acc = '0;
            if (col < nc)
               for (int j = 0; j < no; j++) begin
                  e = j*NCOLS + col;
                  acc = clamp_add(acc, longint'(weights[e]) * longint'(errors[j]));
                  derivs[e] = clamp_add(derivs[e], longint'(errors[j]) * longint'(val));
               end
            w.value = acc;
            w.index = IDX_W'(col);
            w.last  = 1'b1;
            pending_results.push_back(w);
         end
         MODE_READ_D: begin
            w.value = derivs[row*NCOLS+col];
            w.index = {row, col};
            w.last  = 1'b1;
            pending_results.push_back(w);
         end
         MODE_CLEAR_D: foreach (derivs[i]) derivs[i] = '0;
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_word(logic [2:0] mode, logic [3:0] row, logic [3:0] col,
                            logic [VAL_W-1:0] val, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {val, col, row};
      req_tuser = mode;
      req_tlast = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      layer_step(mode, row, col, val, last);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // block must be idle: a no-result word may still be in flight, or a sweep running
   task automatic write_csr(logic idx, logic [CSR_W-1:0] val);
      wait_drained();
      repeat (400) @(negedge clock);
      csr_addr = idx;
      csr_wdata = val;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_CHUNK_SIZE) chunk_reg = val; else out_reg = val;
   endtask

   task automatic set_shape(logic [CSR_W-1:0] chunk, logic [CSR_W-1:0] outs);
      write_csr(CSR_CHUNK_SIZE, chunk);
      write_csr(CSR_OUT_SIZE, outs);
   endtask

   function automatic logic [VAL_W-1:0] rand_val();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h8000;
      if (r == 1) return 16'h7FFF;
      return VAL_W'($urandom());
   endfunction

   // fill every weight the shapes below can read, and every error
   task automatic test_fill_stores();
      for (int r = 0; r < NROWS; r++) begin
         for (int c = 0; c < NCOLS; c++)
            if (r < 3 || c < 2) send_word(MODE_LOAD_W, 4'(r), 4'(c), rand_val(), 1'b0);
         send_word(MODE_LOAD_ERR, 4'(r), 4'd0, rand_val(), 1'b0);
      end
   endtask

   task automatic test_directed();
      set_shape(2, 2);
      send_word(MODE_LOAD_W, 0, 0, 16'h8000, 1'b0);
      send_word(MODE_LOAD_W, 1, 0, 16'h7FFF, 1'b0);
      // positive and negative saturation of the forward sums
      send_word(MODE_FORWARD, 0, 0, 16'h8000, 1'b0);
      send_word(MODE_FORWARD, 0, 0, 16'h8000, 1'b0);
      send_word(MODE_FORWARD, 0, 0, 16'h8000, 1'b1);
      // column past the chunk adds nothing but last is honoured
      send_word(MODE_FORWARD, 0, 15, 16'h7FFF, 1'b1);
      send_word(MODE_LOAD_W, 15, 15, 16'h1234, 1'b0);
      send_word(MODE_LOAD_ERR, 0, 0, 16'h8000, 1'b0);
      send_word(MODE_LOAD_ERR, 1, 0, 16'h8000, 1'b0);
      send_word(MODE_BACKWARD, 0, 0, 16'h8000, 1'b1);
      send_word(MODE_BACKWARD, 0, 0, 16'h7FFF, 1'b0);
      send_word(MODE_BACKWARD, 0, 9, 16'h7FFF, 1'b0);
      send_word(MODE_READ_D, 0, 0, 16'h0, 1'b0);
      send_word(MODE_READ_D, 1, 0, 16'h0, 1'b0);
      send_word(MODE_READ_D, 15, 15, 16'hFFFF, 1'b1);
      send_word(3'd6, 15, 15, 16'hFFFF, 1'b1);
      send_word(3'd7, 0, 0, 16'h0, 1'b0);
      send_word(MODE_CLEAR_D, 0, 0, 16'h0, 1'b0);
      send_word(MODE_READ_D, 0, 0, 16'h0, 1'b0);
      // sender holds off until the result path is empty
      wait_drained();
      send_word(MODE_BACKWARD, 1, 1, 16'h0800, 1'b0);
      send_word(MODE_READ_D, 1, 1, 16'h0, 1'b0);
   endtask

   task automatic test_random_phase(logic [CSR_W-1:0] chunk, logic [CSR_W-1:0] outs, int n);
      int sent, len, nc, r;
      set_shape(chunk, outs);
      nc = cols_used();
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
               send_word(MODE_FORWARD, 4'($urandom()),
                         4'(($urandom_range(0, 9) == 0) ? $urandom()
                                                        : $urandom_range(0, nc-1)),
                         rand_val(), k == len-1);
            sent += len;
         end else begin
            if (r < 62)      send_word(MODE_BACKWARD, 4'($urandom()), 4'($urandom()),
                                       rand_val(), 1'($urandom()));
            else if (r < 72) send_word(MODE_LOAD_ERR, 4'($urandom()), 4'($urandom()),
                                       rand_val(), 1'($urandom()));
            else if (r < 82) send_word(MODE_LOAD_W, 4'($urandom()), 4'($urandom()),
                                       rand_val(), 1'($urandom()));
            else if (r < 93) send_word(MODE_READ_D, 4'($urandom()), 4'($urandom()),
                                       VAL_W'($urandom()), 1'($urandom()));
            else if (r < 95) send_word(MODE_CLEAR_D, 4'($urandom()), 4'($urandom()),
                                       VAL_W'($urandom()), 1'($urandom()));
            else             send_word(3'($urandom_range(6, 7)), 4'($urandom()),
                                       4'($urandom()), VAL_W'($urandom()), 1'($urandom()));
            sent++;
         end
      end
   endtask

   // result side stalls: mostly ready, short and occasional long holds
   always @(negedge clock) begin
      int hold;
      if (hold > 0) begin
         hold--;
         rsp_tready <= 1'b0;
      end else begin
         hold = pick_gap();
         rsp_tready <= (hold == 0);
      end
   end

   always @(posedge clock) begin
      result_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            errors_seen++;
         end else begin
            w = pending_results.pop_front();
            if (rsp_tdata[31:0] !== w.value) begin
               $error("result_value expected %0d actual %0d", w.value,
                      $signed(rsp_tdata[31:0]));
               errors_seen++;
            end
            if (rsp_tdata[39:32] !== w.index) begin
               $error("result_index expected %0d actual %0d", w.index, rsp_tdata[39:32]);
               errors_seen++;
            end
            if (rsp_tlast !== w.last) begin
               $error("result_last expected %0d actual %0d", w.last, rsp_tlast);
               errors_seen++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("shared_weight_chunk_matvec_tb: done, errors");
         $finish;
      end
   end

   initial begin
      foreach (weights[i]) weights[i] = '0;
      foreach (derivs[i]) derivs[i] = '0;
      foreach (row_sums[i]) row_sums[i] = '0;
      foreach (errors[i]) errors[i] = '0;
      chunk_reg = 1;
      out_reg = 1;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_fill_stores();
      test_directed();
      test_random_phase(31, 3, 44);
      test_random_phase(0, 0, 44);
      test_random_phase(2, 31, 44);
      test_random_phase(5, 3, 44);
      test_random_phase(1, 16, 44);
      wait_drained();
      repeat (200) @(negedge clock);
      if (errors_seen == 0 && pending_results.size() == 0)
         $display("shared_weight_chunk_matvec_tb: done, clean");
      else
         $display("shared_weight_chunk_matvec_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
design/swcm_pkg.sv
design/swcm_ram.sv
design/swcm_datapath.sv
design/swcm_ctrl.sv
design/shared_weight_chunk_matvec.sv
tb/shared_weight_chunk_matvec_tb.sv
